FILE: src/tbr_pkg.sv
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared types and constants for the two-button record/send mode controller.
// ----------------------------------------------------------------------------
package tbr_pkg;

    // Register reset values
    localparam logic [7:0]  DEBOUNCE_TICKS_RST      = 8'd5;
    localparam logic [15:0] ERASE_HOLD_TICKS_RST    = 16'd500;
    localparam logic [15:0] LONG_PRESS_TICKS_RST    = 16'd300;
    localparam logic [7:0]  CONFIRM_DELAY_TICKS_RST = 8'd50;
    localparam logic [7:0]  BLINK_PERIOD_TICKS_RST  = 8'd50;
    localparam logic [23:0] FLASH_LAST_ADDRESS_RST  = 24'h06DFFF;
    localparam logic [7:0]  CHUNK_BYTES_RST         = 8'd100;

    // Register indexes on the configuration port
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ERASE_HOLD_TICKS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_DELAY_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_PERIOD_TICKS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FLASH_LAST_ADDRESS  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_BYTES         = 3'd6;
    localparam int CFG_DATA_W = 24;

    // Default module parameters
    localparam int SAMPLE_LIMIT_DEF = 1024;
    localparam int SONG_SLOTS_DEF   = 8;

    // Stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 64;

    // Counter limits
    localparam logic [7:0]  CNT8_MAX  = 8'hFF;
    localparam logic [15:0] CNT16_MAX = 16'hFFFF;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] erase_hold_ticks;
        logic [15:0] long_press_ticks;
        logic [7:0]  confirm_delay_ticks;
        logic [7:0]  blink_period_ticks;
        logic [23:0] flash_last_address;
        logic [7:0]  chunk_bytes;
    } cfg_t;

    // Per-button debounce and hold state
    typedef struct packed {
        logic        stable;
        logic [7:0]  count;
        logic [15:0] hold;
    } btn_state_t;

    // One input tick
    typedef struct packed {
        logic [7:0] key_sample;
        logic       button_two_pressed;
        logic       button_one_pressed;
    } tick_t;

    // One result item
    typedef struct packed {
        logic [7:0]  song_slot;
        logic [7:0]  sample_value;
        logic [7:0]  chunk_length;
        logic [23:0] action_address;
        logic [2:0]  action;
        logic [2:0]  mode;
        logic        led_blue;
        logic        led_green;
        logic        led_red;
    } result_t;

endpackage

FILE: src/tbr_debounce.sv
// ----------------------------------------------------------------------------
// tbr_debounce
// Debounce and hold counting for one button, one tick at a time.
// ----------------------------------------------------------------------------
module tbr_debounce
    import tbr_pkg::*;
(
    input  logic       raw,
    input  logic [7:0] debounce_ticks,
    input  btn_state_t cur,
    output btn_state_t nxt
);

    logic [7:0] count_inc;

    // Saturating persistence counter
    assign count_inc = (cur.count != CNT8_MAX) ? cur.count + 8'd1 : cur.count;

    always_comb
    begin
        nxt = cur;
        if (raw == cur.stable)
        begin
            nxt.count = '0;
        end
        else if (count_inc >= debounce_ticks)
        begin
            nxt.stable = raw;
            nxt.count  = '0;
            if (!raw)
            begin
                nxt.hold = '0;
            end
        end
        else
        begin
            nxt.count = count_inc;
        end
        // Hold length while the settled level is pressed
        if (nxt.stable && nxt.hold != CNT16_MAX)
        begin
            nxt.hold = nxt.hold + 16'd1;
        end
    end

endmodule

FILE: src/tbr_ctrl.sv
// ----------------------------------------------------------------------------
// tbr_ctrl
// Mode controller: state registers, per-tick update logic and result register.
// ----------------------------------------------------------------------------
module tbr_ctrl
    import tbr_pkg::*;
#(
    parameter int SAMPLE_LIMIT = SAMPLE_LIMIT_DEF,
    parameter int SONG_SLOTS   = SONG_SLOTS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    advance,
    input  tick_t   tick,
    input  logic    result_taken,
    output logic    result_valid,
    output result_t result
);

    localparam int SIDX_W = $clog2(SAMPLE_LIMIT + 1);
    localparam logic [SIDX_W-1:0] SIDX_LIMIT = SIDX_W'(SAMPLE_LIMIT);
    localparam logic [7:0] SLOT_LAST = 8'(SONG_SLOTS - 1);

    typedef enum logic [2:0] {
        M_IDLE          = 3'd0,
        M_WAIT_RELEASE  = 3'd1,
        M_RECORD        = 3'd2,
        M_CONFIRM_SEND  = 3'd3,
        M_SENDING       = 3'd4,
        M_CONFIRM_ERASE = 3'd5
    } mode_t;

    localparam logic [2:0] A_NONE   = 3'd0;
    localparam logic [2:0] A_STORE  = 3'd1;
    localparam logic [2:0] A_COMMIT = 3'd2;
    localparam logic [2:0] A_SEND   = 3'd3;
    localparam logic [2:0] A_ERASE  = 3'd4;

    mode_t             mode_reg, mode_next;
    btn_state_t        btn1_reg, btn1_next, btn1_deb;
    btn_state_t        btn2_reg, btn2_next, btn2_deb;
    logic [7:0]        send_wait_reg, send_wait_next;
    logic [7:0]        erase_wait_reg, erase_wait_next;
    logic [7:0]        blink_reg, blink_next;
    logic [2:0]        led_reg, led_next;
    logic [23:0]       send_addr_reg, send_addr_next;
    logic [SIDX_W-1:0] sample_idx_reg, sample_idx_next;
    logic [7:0]        slot_reg, slot_next;
    logic              result_valid_reg;
    result_t           result_reg, result_next;

    logic [7:0]  blink_inc;
    logic [7:0]  wait_inc;
    logic [23:0] addr_gap;
    logic [7:0]  chunk_most;
    logic        chunk_full;
    logic [7:0]  chunk_len;

    tbr_debounce u_deb_one (
        .raw            (tick.button_one_pressed),
        .debounce_ticks (cfg.debounce_ticks),
        .cur            (btn1_reg),
        .nxt            (btn1_deb)
    );

    tbr_debounce u_deb_two (
        .raw            (tick.button_two_pressed),
        .debounce_ticks (cfg.debounce_ticks),
        .cur            (btn2_reg),
        .nxt            (btn2_deb)
    );

    // Chunk sizing for the sending mode
    assign addr_gap   = cfg.flash_last_address - send_addr_reg;
    assign chunk_most = (cfg.chunk_bytes == 8'd0) ? 8'd1 : cfg.chunk_bytes;
    assign chunk_full = (addr_gap >= {16'd0, chunk_most});
    assign chunk_len  = chunk_full ? chunk_most : addr_gap[7:0] + 8'd1;

    assign blink_inc = (blink_reg != CNT8_MAX) ? blink_reg + 8'd1 : blink_reg;
    assign wait_inc  = (mode_reg == M_CONFIRM_SEND)
                     ? ((send_wait_reg != CNT8_MAX) ? send_wait_reg + 8'd1 : send_wait_reg)
                     : ((erase_wait_reg != CNT8_MAX) ? erase_wait_reg + 8'd1 : erase_wait_reg);

    // Per-tick update
    always_comb
    begin
        mode_next       = mode_reg;
        btn1_next       = btn1_deb;
        btn2_next       = btn2_deb;
        send_wait_next  = send_wait_reg;
        erase_wait_next = erase_wait_reg;
        blink_next      = blink_inc;
        led_next        = led_reg;
        send_addr_next  = send_addr_reg;
        sample_idx_next = sample_idx_reg;
        slot_next       = slot_reg;
        result_next     = '0;
        result_next.action = A_NONE;

        // LED blinking in send and erase modes (bit 0 red, 2 blue)
        if ((mode_reg == M_SENDING || mode_reg == M_CONFIRM_ERASE) &&
            blink_inc >= cfg.blink_period_ticks)
        begin
            if (mode_reg == M_SENDING)
            begin
                led_next[2] = ~led_reg[2];
            end
            else
            begin
                led_next = ~led_reg;
            end
            blink_next = '0;
        end

        case (mode_reg)
            M_WAIT_RELEASE:
            begin
                if (btn2_deb.hold >= cfg.long_press_ticks)
                begin
                    mode_next      = M_CONFIRM_SEND;
                    btn2_next.hold = '0;
                    send_wait_next = '0;
                end
                else if (btn2_deb.hold == 16'd0)
                begin
                    mode_next       = M_RECORD;
                    sample_idx_next = '0;
                end
            end
            M_RECORD:
            begin
                led_next = 3'b010;
                if (btn1_deb.hold == 16'd1 || sample_idx_reg >= SIDX_LIMIT)
                begin
                    result_next.action    = A_COMMIT;
                    result_next.song_slot = slot_reg;
                    slot_next = (slot_reg >= SLOT_LAST) ? 8'd0 : slot_reg + 8'd1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    result_next.action         = A_STORE;
                    result_next.action_address = 24'(sample_idx_reg);
                    result_next.sample_value   = tick.key_sample;
                    sample_idx_next            = sample_idx_reg + 1'b1;
                end
            end
            M_CONFIRM_SEND:
            begin
                led_next       = 3'b100;
                send_wait_next = wait_inc;
                if (wait_inc >= cfg.confirm_delay_ticks && btn2_deb.hold == 16'd1)
                begin
                    mode_next      = M_SENDING;
                    send_addr_next = '0;
                    blink_next     = '0;
                end
                else if (wait_inc >= cfg.confirm_delay_ticks && btn1_deb.hold == 16'd1)
                begin
                    mode_next = M_IDLE;
                end
            end
            M_SENDING:
            begin
                if (send_addr_reg > cfg.flash_last_address)
                begin
                    mode_next = M_IDLE;
                end
                else
                begin
                    result_next.action         = A_SEND;
                    result_next.action_address = send_addr_reg;
                    result_next.chunk_length   = chunk_len;
                    send_addr_next = send_addr_reg + {16'd0, chunk_len};
                    if (!chunk_full)
                    begin
                        mode_next = M_IDLE;
                    end
                end
            end
            M_CONFIRM_ERASE:
            begin
                erase_wait_next = wait_inc;
                if (wait_inc >= cfg.confirm_delay_ticks && btn2_deb.stable &&
                    btn2_deb.hold == 16'd1)
                begin
                    result_next.action = A_ERASE;
                    mode_next          = M_IDLE;
                end
                else if (wait_inc >= cfg.confirm_delay_ticks && btn1_deb.stable &&
                         btn1_deb.hold == 16'd1)
                begin
                    mode_next = M_IDLE;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
                led_next  = 3'b001;
                if (btn2_deb.hold == 16'd1)
                begin
                    mode_next        = M_WAIT_RELEASE;
                    btn2_next.count  = '0;
                    btn2_next.stable = 1'b1;
                end
                else if (btn1_deb.hold >= cfg.erase_hold_ticks)
                begin
                    mode_next       = M_CONFIRM_ERASE;
                    led_next        = 3'b000;
                    btn1_next.hold  = '0;
                    erase_wait_next = '0;
                end
            end
        endcase

        result_next.led_red   = led_next[0];
        result_next.led_green = led_next[1];
        result_next.led_blue  = led_next[2];
        result_next.mode      = mode_next;
    end

    // State and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= M_IDLE;
            btn1_reg         <= '0;
            btn2_reg         <= '0;
            send_wait_reg    <= '0;
            erase_wait_reg   <= '0;
            blink_reg        <= '0;
            led_reg          <= '0;
            send_addr_reg    <= '0;
            sample_idx_reg   <= '0;
            slot_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg         <= mode_next;
                btn1_reg         <= btn1_next;
                btn2_reg         <= btn2_next;
                send_wait_reg    <= send_wait_next;
                erase_wait_reg   <= erase_wait_next;
                blink_reg        <= blink_next;
                led_reg          <= led_next;
                send_addr_reg    <= send_addr_next;
                sample_idx_reg   <= sample_idx_next;
                slot_reg         <= slot_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_taken)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: src/two_button_record_send_mode_control_core.sv
// ----------------------------------------------------------------------------
// two_button_record_send_mode_control_core
// Top level: tick input register, configuration registers, mode controller.
// ----------------------------------------------------------------------------
// One input transaction is one timer tick (two raw button levels and a key
// sample); every tick produces exactly one result transaction carrying the LED
// levels, the mode after the tick and one action. Throughput is one tick per
// clock unless the output stalls; a tick passes the input register, then the
// result register written by the combinational controller update. A new tick
// is taken while a finished result waits on the output. Configuration writes
// are taken at any time but should only be issued while no tick is in flight.
// ----------------------------------------------------------------------------
module two_button_record_send_mode_control_core
    import tbr_pkg::*;
#(
    parameter int SAMPLE_LIMIT = SAMPLE_LIMIT_DEF,
    parameter int SONG_SLOTS   = SONG_SLOTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Tick input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] button_one_pressed, [1] button_two_pressed, [9:2] key_sample, [15:10] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] led_red, [1] led_green, [2] led_blue, [5:3] mode, [8:6] action,
    // [32:9] action_address, [40:33] chunk_length, [48:41] sample_value,
    // [56:49] song_slot, [63:57] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    tick_t   tick_reg;
    logic    advance;
    logic    result_valid;
    result_t result;

    // Controller advances when a tick is held and the result slot frees up
    assign advance       = in_valid_reg && (!result_valid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks      <= DEBOUNCE_TICKS_RST;
            cfg_reg.erase_hold_ticks    <= ERASE_HOLD_TICKS_RST;
            cfg_reg.long_press_ticks    <= LONG_PRESS_TICKS_RST;
            cfg_reg.confirm_delay_ticks <= CONFIRM_DELAY_TICKS_RST;
            cfg_reg.blink_period_ticks  <= BLINK_PERIOD_TICKS_RST;
            cfg_reg.flash_last_address  <= FLASH_LAST_ADDRESS_RST;
            cfg_reg.chunk_bytes         <= CHUNK_BYTES_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS:      cfg_reg.debounce_ticks      <= cfg_data[7:0];
                REG_ERASE_HOLD_TICKS:    cfg_reg.erase_hold_ticks    <= cfg_data[15:0];
                REG_LONG_PRESS_TICKS:    cfg_reg.long_press_ticks    <= cfg_data[15:0];
                REG_CONFIRM_DELAY_TICKS: cfg_reg.confirm_delay_ticks <= cfg_data[7:0];
                REG_BLINK_PERIOD_TICKS:  cfg_reg.blink_period_ticks  <= cfg_data[7:0];
                REG_FLASH_LAST_ADDRESS:  cfg_reg.flash_last_address  <= cfg_data;
                REG_CHUNK_BYTES:         cfg_reg.chunk_bytes         <= cfg_data[7:0];
                default:                 ;
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            tick_reg <= s_axis_tdata[9:0];
        end
    end

    tbr_ctrl #(
        .SAMPLE_LIMIT (SAMPLE_LIMIT),
        .SONG_SLOTS   (SONG_SLOTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .advance      (advance),
        .tick         (tick_reg),
        .result_taken (m_axis_tready),
        .result_valid (result_valid),
        .result       (result)
    );

    assign m_axis_tvalid = result_valid;
    assign m_axis_tdata  = {7'd0, result};

endmodule

FILE: sim/mode_control_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mode_control_checker
// Watches the tick and result streams and the configuration port, predicts
// every result of the two-button mode controller and compares field by field.
// ----------------------------------------------------------------------------
module mode_control_checker
    import tbr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output int                     mismatch_count,
    output int                     pending_results
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WAIT_RELEASE,
        MODE_RECORD,
        MODE_CONFIRM_SEND,
        MODE_SENDING,
        MODE_CONFIRM_ERASE
    } mode_e;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_STORE,
        ACT_COMMIT,
        ACT_SEND,
        ACT_ERASE
    } action_e;

    // Shadow of the block's registers and state
    cfg_t        cfg;
    mode_e       mode_q;
    logic        btn_stable [2];
    logic [7:0]  btn_count  [2];
    logic [15:0] btn_hold   [2];
    logic [7:0]  send_wait;
    logic [7:0]  erase_wait;
    logic [7:0]  blink_cnt;
    logic [2:0]  leds;          // [0] red, [1] green, [2] blue
    logic [23:0] send_addr;
    logic [10:0] sample_idx;
    logic [7:0]  slot_idx;

    result_t expected_results [$];
    int      result_count;

    // Debounce one raw button level and advance its hold count
    function automatic void debounce_button(int k, logic raw);
        if (raw == btn_stable[k]) begin
            btn_count[k] = '0;
        end
        else begin
            if (btn_count[k] != CNT8_MAX)
                btn_count[k]++;
            if (btn_count[k] >= cfg.debounce_ticks) begin
                btn_stable[k] = raw;
                btn_count[k]  = '0;
                if (!raw)
                    btn_hold[k] = '0;
            end
        end
        if (btn_stable[k] && btn_hold[k] != CNT16_MAX)
            btn_hold[k]++;
    endfunction

    // One tick through the controller: returns the result it yields
    function automatic result_t predict_tick(tick_t t);
        result_t     r;
        logic [31:0] remaining;
        logic [31:0] most;
        logic [31:0] chunk;
        logic [31:0] next_addr;
        r = '0;
        if (blink_cnt != CNT8_MAX)
            blink_cnt++;
        debounce_button(0, t.button_one_pressed);
        debounce_button(1, t.button_two_pressed);

        // LED blinking in sending and confirm erase
        if ((mode_q == MODE_SENDING || mode_q == MODE_CONFIRM_ERASE) &&
            blink_cnt >= cfg.blink_period_ticks) begin
            if (mode_q == MODE_SENDING)
                leds[2] = ~leds[2];
            else
                leds = ~leds;
            blink_cnt = '0;
        end

        case (mode_q)
            MODE_WAIT_RELEASE: begin
                if (btn_hold[1] >= cfg.long_press_ticks) begin
                    mode_q      = MODE_CONFIRM_SEND;
                    btn_hold[1] = '0;
                    send_wait   = '0;
                end
                else if (btn_hold[1] == 16'd0) begin
                    mode_q     = MODE_RECORD;
                    sample_idx = '0;
                end
            end
            MODE_RECORD: begin
                leds = 3'b010;
                if (btn_hold[0] == 16'd1 || sample_idx >= SAMPLE_LIMIT_DEF) begin
                    r.action    = ACT_COMMIT;
                    r.song_slot = slot_idx;
                    slot_idx    = 8'((int'(slot_idx) + 1) % SONG_SLOTS_DEF);
                    mode_q      = MODE_IDLE;
                end
                else begin
                    r.action         = ACT_STORE;
                    r.action_address = 24'(sample_idx);
                    r.sample_value   = t.key_sample;
                    sample_idx++;
                end
            end
            MODE_CONFIRM_SEND: begin
                leds = 3'b100;
                if (send_wait != CNT8_MAX)
                    send_wait++;
                if (send_wait >= cfg.confirm_delay_ticks && btn_hold[1] == 16'd1) begin
                    mode_q    = MODE_SENDING;
                    send_addr = '0;
                    blink_cnt = '0;
                end
                else if (send_wait >= cfg.confirm_delay_ticks && btn_hold[0] == 16'd1) begin
                    mode_q = MODE_IDLE;
                end
            end
            MODE_SENDING: begin
                if (send_addr > cfg.flash_last_address) begin
                    mode_q = MODE_IDLE;
                end
                else begin
                    remaining = {8'd0, cfg.flash_last_address} + 32'd1 - {8'd0, send_addr};
                    most      = (cfg.chunk_bytes == 8'd0) ? 32'd1 : {24'd0, cfg.chunk_bytes};
                    chunk     = (remaining > most) ? most : remaining;
                    next_addr = {8'd0, send_addr} + chunk;
                    r.action         = ACT_SEND;
                    r.action_address = send_addr;
                    r.chunk_length   = chunk[7:0];
                    if (next_addr > {8'd0, cfg.flash_last_address})
                        mode_q = MODE_IDLE;
                    send_addr = next_addr[23:0];
                end
            end
            MODE_CONFIRM_ERASE: begin
                if (erase_wait != CNT8_MAX)
                    erase_wait++;
                if (erase_wait >= cfg.confirm_delay_ticks && btn_stable[1] &&
                    btn_hold[1] == 16'd1) begin
                    r.action = ACT_ERASE;
                    mode_q   = MODE_IDLE;
                end
                else if (erase_wait >= cfg.confirm_delay_ticks && btn_stable[0] &&
                         btn_hold[0] == 16'd1) begin
                    mode_q = MODE_IDLE;
                end
            end
            default: begin
                mode_q = MODE_IDLE;
                leds   = 3'b001;
                if (btn_hold[1] == 16'd1) begin
                    mode_q        = MODE_WAIT_RELEASE;
                    btn_count[1]  = '0;
                    btn_stable[1] = 1'b1;
                end
                else if (btn_hold[0] >= cfg.erase_hold_ticks) begin
                    mode_q      = MODE_CONFIRM_ERASE;
                    leds[0]     = 1'b0;
                    btn_hold[0] = '0;
                    erase_wait  = '0;
                end
            end
        endcase

        r.led_red   = leds[0];
        r.led_green = leds[1];
        r.led_blue  = leds[2];
        r.mode      = mode_q;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: result %0d %s expected 0x%0h, got 0x%0h",
                     $time, result_count, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Track configuration, predict accepted ticks, compare accepted results
    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            cfg.debounce_ticks      = DEBOUNCE_TICKS_RST;
            cfg.erase_hold_ticks    = ERASE_HOLD_TICKS_RST;
            cfg.long_press_ticks    = LONG_PRESS_TICKS_RST;
            cfg.confirm_delay_ticks = CONFIRM_DELAY_TICKS_RST;
            cfg.blink_period_ticks  = BLINK_PERIOD_TICKS_RST;
            cfg.flash_last_address  = FLASH_LAST_ADDRESS_RST;
            cfg.chunk_bytes         = CHUNK_BYTES_RST;
            mode_q        = MODE_IDLE;
            btn_stable[0] = 1'b0;
            btn_stable[1] = 1'b0;
            btn_count[0]  = '0;
            btn_count[1]  = '0;
            btn_hold[0]   = '0;
            btn_hold[1]   = '0;
            send_wait     = '0;
            erase_wait    = '0;
            blink_cnt     = '0;
            leds          = '0;
            send_addr     = '0;
            sample_idx    = '0;
            slot_idx      = '0;
            expected_results.delete();
            result_count   = 0;
            mismatch_count = 0;
            pending_results <= 0;
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DEBOUNCE_TICKS:      cfg.debounce_ticks      = cfg_data[7:0];
                    REG_ERASE_HOLD_TICKS:    cfg.erase_hold_ticks    = cfg_data[15:0];
                    REG_LONG_PRESS_TICKS:    cfg.long_press_ticks    = cfg_data[15:0];
                    REG_CONFIRM_DELAY_TICKS: cfg.confirm_delay_ticks = cfg_data[7:0];
                    REG_BLINK_PERIOD_TICKS:  cfg.blink_period_ticks  = cfg_data[7:0];
                    REG_FLASH_LAST_ADDRESS:  cfg.flash_last_address  = cfg_data[23:0];
                    REG_CHUNK_BYTES:         cfg.chunk_bytes         = cfg_data[7:0];
                    default: ;
                endcase
            end

            // Result side first: a result never belongs to a tick taken this edge
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(result_t)-1:0];
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result %0d arrived with none expected, got 0x%0h",
                             $time, result_count, got);
                    mismatch_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("led_red",        32'(want.led_red),        32'(got.led_red));
                    check_field("led_green",      32'(want.led_green),      32'(got.led_green));
                    check_field("led_blue",       32'(want.led_blue),       32'(got.led_blue));
                    check_field("mode",           32'(want.mode),           32'(got.mode));
                    check_field("action",         32'(want.action),         32'(got.action));
                    check_field("action_address", 32'(want.action_address),
                                32'(got.action_address));
                    check_field("chunk_length",   32'(want.chunk_length),   32'(got.chunk_length));
                    check_field("sample_value",   32'(want.sample_value),   32'(got.sample_value));
                    check_field("song_slot",      32'(want.song_slot),      32'(got.song_slot));
                end
                result_count++;
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_tick(s_axis_tdata[$bits(tick_t)-1:0]));

            pending_results <= expected_results.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the two-button record/send mode controller.
// ----------------------------------------------------------------------------
// Drives button gestures (record, send, erase, bounces and noise) as tick
// transactions under a series of register settings, with random gaps on the
// tick stream and random back-pressure on the result stream. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import tbr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int pending_results;
    int cycle_count;
    int ticks_sent;
    bit steady;

    // Register values currently loaded, used to size gestures
    int unsigned cur_debounce;
    int unsigned cur_erase_hold;
    int unsigned cur_long_press;
    int unsigned cur_confirm;
    int unsigned cur_blink;
    int unsigned cur_last_addr;
    int unsigned cur_chunk;

    two_button_record_send_mode_control_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mode_control_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Result back-pressure: free-running stretches, short toggles, long stalls
    initial
    begin : result_stall
        int unsigned pick;
        int unsigned len;
        logic        lvl;
        m_axis_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                len = $urandom_range(20, 120);
                lvl = 1'b1;
            end
            else if (pick < 8)
            begin
                len = $urandom_range(1, 3);
                lvl = 1'($urandom_range(0, 1));
            end
            else
            begin
                len = $urandom_range(10, 40);
                lvl = 1'b0;
            end
            repeat (len)
            begin
                m_axis_tready <= lvl;
                @(posedge clk);
            end
        end
    end

    // One tick transaction, with an optional gap before it
    task automatic send_tick(input logic b1, input logic b2, input logic [7:0] key);
        tick_t       t;
        int unsigned r;
        int unsigned gap;
        t.button_one_pressed = b1;
        t.button_two_pressed = b2;
        t.key_sample         = key;
        r   = $urandom_range(0, 99);
        gap = (steady || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(t);
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic hold_levels(input logic b1, input logic b2, input int unsigned n);
        repeat (n) send_tick(b1, b2, 8'($urandom_range(0, 255)));
    endtask

    // Sender holds off until every result is in
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (index)
            REG_DEBOUNCE_TICKS:      cur_debounce   = value;
            REG_ERASE_HOLD_TICKS:    cur_erase_hold = value;
            REG_LONG_PRESS_TICKS:    cur_long_press = value;
            REG_CONFIRM_DELAY_TICKS: cur_confirm    = value;
            REG_BLINK_PERIOD_TICKS:  cur_blink      = value;
            REG_FLASH_LAST_ADDRESS:  cur_last_addr  = value;
            REG_CHUNK_BYTES:         cur_chunk      = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned deb, input int unsigned erase_hold,
                              input int unsigned long_press, input int unsigned confirm,
                              input int unsigned blink, input int unsigned last_addr,
                              input int unsigned chunk);
        wait_drained();
        write_reg(REG_DEBOUNCE_TICKS, deb);
        write_reg(REG_ERASE_HOLD_TICKS, erase_hold);
        write_reg(REG_LONG_PRESS_TICKS, long_press);
        write_reg(REG_CONFIRM_DELAY_TICKS, confirm);
        write_reg(REG_BLINK_PERIOD_TICKS, blink);
        write_reg(REG_FLASH_LAST_ADDRESS, last_addr);
        write_reg(REG_CHUNK_BYTES, chunk);
    endtask

    function automatic int unsigned capped(int unsigned v);
        return (v > 400) ? 400 : v;
    endfunction

    // One random button gesture sized to the loaded registers
    task automatic play_gesture();
        int unsigned kind;
        int unsigned dd;
        int unsigned eff;
        int unsigned chunks;
        dd     = (cur_debounce == 0) ? 1 : cur_debounce;
        steady = ($urandom_range(0, 3) == 0);
        kind   = $urandom_range(0, 99);
        if (kind < 10)
        begin
            // raw noise
            repeat ($urandom_range(1, 12))
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
        end
        else if (kind < 18)
        begin
            // contact bounce, mostly shorter than the debounce time
            repeat ($urandom_range(1, 4))
            begin
                hold_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            $urandom_range(1, dd));
                hold_levels(1'b0, 1'b0, $urandom_range(1, dd));
            end
        end
        else if (kind < 50)
        begin
            // short press of button two, record, commit with button one
            hold_levels(1'b0, 1'b1, dd + $urandom_range(0, capped(cur_long_press)));
            hold_levels(1'b0, 1'b0, dd + $urandom_range(0, 40));
            hold_levels(1'b1, 1'b0, dd + $urandom_range(0, 4));
            hold_levels(1'b0, 1'b0, dd + $urandom_range(0, 3));
        end
        else if (kind < 78)
        begin
            // long press of button two, then confirm or cancel the send
            hold_levels(1'b0, 1'b1, dd + capped(cur_long_press) + $urandom_range(0, 3));
            hold_levels(1'b0, 1'b0, dd + $urandom_range(0, 3));
            hold_levels(1'b0, 1'b0, $urandom_range(0, capped(cur_confirm) + 3));
            if ($urandom_range(0, 3) != 0)
                hold_levels(1'b0, 1'b1, dd + $urandom_range(0, 3));
            else
                hold_levels(1'b1, 0'b0 == 0 ? 1'b0 : 1'b0, dd + $urandom_range(0, 3));
            eff    = (cur_chunk == 0) ? 1 : cur_chunk;
            chunks = (cur_last_addr + eff) / eff;
            hold_levels(1'b0, 1'b0, dd + ((chunks > 2000) ? 2000 : chunks) +
                        $urandom_range(0, 10));
        end
        else if (kind < 96)
        begin
            // long press of button one, then confirm or cancel the erase
            hold_levels(1'b1, 1'b0, dd + capped(cur_erase_hold) + $urandom_range(0, 3));
            hold_levels(1'b0, 1'b0, dd + $urandom_range(0, 3));
            hold_levels(1'b0, 1'b0, $urandom_range(0, capped(cur_confirm) + 3));
            if ($urandom_range(0, 2) != 0)
                hold_levels(1'b0, 1'b1, dd + $urandom_range(0, 3));
            else
                hold_levels(1'b1, 1'b0, dd + $urandom_range(0, 3));
            hold_levels(1'b0, 1'b0, dd + $urandom_range(0, 5));
        end
        else
        begin
            wait_drained();
        end
    endtask

    initial
    begin : stimulus
        int unsigned chunk;
        int unsigned eff;
        int unsigned budget;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        ticks_sent    = 0;
        steady        = 1'b0;
        cur_debounce   = DEBOUNCE_TICKS_RST;
        cur_erase_hold = ERASE_HOLD_TICKS_RST;
        cur_long_press = LONG_PRESS_TICKS_RST;
        cur_confirm    = CONFIRM_DELAY_TICKS_RST;
        cur_blink      = BLINK_PERIOD_TICKS_RST;
        cur_last_addr  = FLASH_LAST_ADDRESS_RST;
        cur_chunk      = CHUNK_BYTES_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a few ticks with extreme key values
        send_tick(1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 1'b1, 8'hFF);
        send_tick(1'b0, 1'b1, 8'hA5);

        // Zero debounce, zero erase hold, zero blink, one-byte chunks
        set_config(0, 0, 2, 0, 0, 2, 0);
        send_tick(1'b0, 1'b0, 8'h00);
        send_tick(1'b0, 1'b0, 8'hFF);
        send_tick(1'b0, 1'b1, 8'hA5);
        send_tick(1'b0, 1'b1, 8'h5A);
        send_tick(1'b1, 1'b0, 8'h0F);
        send_tick(1'b0, 1'b0, 8'hF0);
        send_tick(1'b1, 1'b1, 8'h3C);
        send_tick(1'b0, 1'b0, 8'hC3);

        // Erase hold of one, last address zero, widest chunk
        set_config(1, 1, 2, 1, 1, 0, 255);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        send_tick(1'b0, 1'b1, 8'h01);
        send_tick(1'b0, 1'b1, 8'h02);
        send_tick(1'b0, 1'b1, 8'h04);
        send_tick(1'b0, 1'b0, 8'h08);
        send_tick(1'b0, 1'b1, 8'h10);
        send_tick(1'b0, 1'b0, 8'h20);
        send_tick(1'b0, 1'b0, 8'h40);
        send_tick(1'b0, 1'b1, 8'h80);
        send_tick(1'b0, 1'b0, 8'h00);
        send_tick(1'b0, 1'b0, 8'hFF);
        send_tick(1'b1, 1'b0, 8'h7E);
        send_tick(1'b0, 1'b0, 8'h81);

        // Random phases with small thresholds so every mode is reached
        for (int p = 0; p < 5; p++)
        begin
            chunk = $urandom_range(0, 255);
            eff   = (chunk == 0) ? 1 : chunk;
            set_config($urandom_range(0, 4), $urandom_range(2, 40), $urandom_range(6, 30),
                       $urandom_range(1, 10), $urandom_range(0, 8),
                       $urandom_range(0, eff * 30), chunk);
            if (p == 2)
            begin
                // record until the sample store is full
                hold_levels(1'b0, 1'b1, (cur_debounce == 0) ? 1 : cur_debounce);
                hold_levels(1'b0, 1'b0, cur_debounce + SAMPLE_LIMIT_DEF + 8);
            end
            budget = ticks_sent + 280;
            while (ticks_sent < budget)
                play_gesture();
        end

        // Largest values: long debounce, no send or erase reachable
        set_config(255, 65535, 65535, 255, 255, 24'hFFFFFF, 255);
        steady = 1'b0;
        hold_levels(1'b1, 1'b0, 100);
        hold_levels(1'b0, 1'b1, 256);
        hold_levels(1'b0, 1'b0, 256);
        hold_levels(1'b0, 1'b0, 20);

        // Long confirm delay: wait counters run into saturation
        set_config(1, 2, 4, 255, 1, 20, 7);
        hold_levels(1'b1, 1'b0, 3);
        hold_levels(1'b0, 1'b0, 300);
        hold_levels(1'b0, 1'b1, 2);
        hold_levels(1'b0, 1'b0, 3);
        hold_levels(1'b0, 1'b1, 6);
        hold_levels(1'b0, 1'b0, 300);
        hold_levels(1'b0, 1'b1, 2);
        hold_levels(1'b0, 1'b0, 10);

        // Back to the reset values
        set_config(DEBOUNCE_TICKS_RST, ERASE_HOLD_TICKS_RST, LONG_PRESS_TICKS_RST,
                   CONFIRM_DELAY_TICKS_RST, BLINK_PERIOD_TICKS_RST,
                   FLASH_LAST_ADDRESS_RST, CHUNK_BYTES_RST);
        budget = ticks_sent + 60;
        while (ticks_sent < budget)
            play_gesture();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
src/tbr_pkg.sv
src/tbr_debounce.sv
src/tbr_ctrl.sv
src/two_button_record_send_mode_control_core.sv
sim/mode_control_checker.sv
sim/tb_top.sv
